// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GBS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gbs assertion failed");
`define GBS_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("gbs assertion failed");
`else
`define GBS_ASSERT(label, clk, rst_n, prop)
`define GBS_ASSERT_NR(label, clk, prop)
`endif
`endif

// ----- rtl/gbs_pkg.sv -----
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared constants and types of the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int unsigned MAX_KEPT_DEF = 64;
    localparam int unsigned Q_DEPTH      = 2;
    localparam int unsigned Q_PTR_W      = 1;
    localparam int unsigned Q_CNT_W      = 2;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned SIZE_W  = 15;
    localparam int unsigned AREA_W  = 30;
    localparam int unsigned USUM_W  = 31;
    localparam int unsigned THR_W   = 16;
    localparam int unsigned PROD_W  = 47;
    localparam int unsigned INDEX_W = 16;

    localparam logic [THR_W-1:0] IOU_THR_RESET = 16'd29491;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
        logic [AREA_W-1:0]         area;
    } t_box_geom;

    typedef struct packed {
        t_box_geom          geom;
        logic [INDEX_W-1:0] index;
        logic               last;
    } t_box_item;

    typedef struct packed {
        logic in_done;
        logic pipe_busy;
    } t_back_stat;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_back_state;

endpackage

// ----- rtl/gbs_box_if.sv -----
// ----------------------------------------------------------------------------
// gbs_box_if
// Input box channel: valid/ready handshake with box geometry payload.
// ----------------------------------------------------------------------------
interface gbs_box_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic [14:0]        box_width;
    logic [14:0]        box_height;
    logic               last_box;

    modport source (output valid, box_left, box_top, box_width, box_height, last_box,
                    input ready);
    modport sink (input valid, box_left, box_top, box_width, box_height, last_box,
                  output ready);
endinterface

// ----- rtl/gbs_res_if.sv -----
// ----------------------------------------------------------------------------
// gbs_res_if
// Result channel: valid/ready handshake with per-box verdict payload.
// ----------------------------------------------------------------------------
interface gbs_res_if;
    logic        valid;
    logic        ready;
    logic        keep;
    logic [15:0] box_index;
    logic        table_full;
    logic        set_done;

    modport source (output valid, keep, box_index, table_full, set_done, input ready);
    modport sink (input valid, keep, box_index, table_full, set_done, output ready);
endinterface

// ----- rtl/gbs_cfg_if.sv -----
// ----------------------------------------------------------------------------
// gbs_cfg_if
// Configuration write channel for the overlap threshold register.
// ----------------------------------------------------------------------------
interface gbs_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] iou_threshold;

    modport source (output valid, iou_threshold, input ready);
    modport sink (input valid, iou_threshold, output ready);
endinterface

// ----- rtl/gbs_front.sv -----
// ----------------------------------------------------------------------------
// gbs_front
// Accept boxes, compute area, tag with index in set, push to queue.
// ----------------------------------------------------------------------------
module gbs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gbs_box_if.sink            i_box,
    input  logic               i_q_full,
    output logic               o_q_push,
    output gbs_pkg::t_box_item o_q_item
);
    import gbs_pkg::*;

    logic [INDEX_W-1:0] r_item_cnt, n_item_cnt;

    assign i_box.ready = !i_q_full;
    assign o_q_push    = i_box.valid && !i_q_full;

    always_comb begin
        o_q_item.geom.left   = i_box.box_left;
        o_q_item.geom.top    = i_box.box_top;
        o_q_item.geom.width  = i_box.box_width;
        o_q_item.geom.height = i_box.box_height;
        o_q_item.geom.area   = AREA_W'(i_box.box_width) * AREA_W'(i_box.box_height);
        o_q_item.index       = r_item_cnt;
        o_q_item.last        = i_box.last_box;
    end

    always_comb begin
        n_item_cnt = r_item_cnt;
        if (o_q_push) begin
            if (i_box.last_box) begin
                n_item_cnt = '0;
            end else if (r_item_cnt != '1) begin
                n_item_cnt = r_item_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_cnt <= '0;
        end else begin
            r_item_cnt <= n_item_cnt;
        end
    end

endmodule

// ----- rtl/gbs_queue.sv -----
// ----------------------------------------------------------------------------
// gbs_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module gbs_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gbs_pkg::t_box_item i_item,
    output logic               o_full,
    input  logic               i_pop,
    output gbs_pkg::t_box_item o_item,
    output logic               o_empty
);
    import gbs_pkg::*;

    t_box_item          r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_slot[r_rd_ptr];

    function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
        logic [Q_PTR_W-1:0] q;
        q = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- rtl/gbs_back.sv -----
// ----------------------------------------------------------------------------
// gbs_back
// Compare one box against the kept table, one entry per cycle, through a
// four stage overlap pipeline; store kept boxes and register the result.
// ----------------------------------------------------------------------------
module gbs_back #(
    parameter int unsigned MAX_KEPT = gbs_pkg::MAX_KEPT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [gbs_pkg::THR_W-1:0] i_thr,
    input  logic                      i_q_empty,
    input  gbs_pkg::t_box_item        i_q_item,
    output logic                      o_q_pop,
    gbs_res_if.source                 o_res,
    output gbs_pkg::t_back_stat       o_stat
);
    import gbs_pkg::*;

    localparam int unsigned CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int unsigned ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

    t_box_geom   r_mem [MAX_KEPT];
    t_back_state r_state, n_state;
    t_box_item   r_cur;
    t_box_geom   r_rd;

    logic [CNT_W-1:0]  r_kept_cnt, r_issue;
    logic              r_v1, r_v2, r_v3, r_v4, r_supp;
    logic [SIZE_W-1:0] r_dx, r_dy;
    logic [AREA_W-1:0] r_karea, r_inter, r_inter3;
    logic [USUM_W-1:0] r_usum;
    logic [PROD_W-1:0] r_prod;

    logic               r_out_valid, r_keep, r_full, r_done;
    logic [INDEX_W-1:0] r_index;

    logic                      issue, pipe_busy, out_free, room, fire, keep_now, over;
    logic signed [COORD_W:0]   cx2, kx2, cy2, ky2, x2, y2;
    logic signed [COORD_W-1:0] x1, y1;
    logic signed [COORD_W+1:0] dx_s, dy_s;
    logic [USUM_W-1:0]         uni;

    assign issue     = (r_state == ST_RUN) && (r_issue < r_kept_cnt);
    assign pipe_busy = r_v1 || r_v2 || r_v3 || r_v4;
    assign out_free  = !r_out_valid || o_res.ready;
    assign room      = (r_kept_cnt < CNT_W'(MAX_KEPT));
    assign fire      = (r_state == ST_DONE) && out_free;
    assign keep_now  = !r_supp;
    assign o_q_pop   = (r_state == ST_IDLE) && !i_q_empty;

    assign o_stat.in_done   = (r_state == ST_DONE);
    assign o_stat.pipe_busy = pipe_busy;

    always_comb begin
        cx2  = {r_cur.geom.left[COORD_W-1], r_cur.geom.left} + {2'b00, r_cur.geom.width};
        kx2  = {r_rd.left[COORD_W-1], r_rd.left} + {2'b00, r_rd.width};
        cy2  = {r_cur.geom.top[COORD_W-1], r_cur.geom.top} + {2'b00, r_cur.geom.height};
        ky2  = {r_rd.top[COORD_W-1], r_rd.top} + {2'b00, r_rd.height};
        x1   = (r_cur.geom.left > r_rd.left) ? r_cur.geom.left : r_rd.left;
        y1   = (r_cur.geom.top > r_rd.top) ? r_cur.geom.top : r_rd.top;
        x2   = (cx2 < kx2) ? cx2 : kx2;
        y2   = (cy2 < ky2) ? cy2 : ky2;
        dx_s = {x2[COORD_W], x2} - {{2{x1[COORD_W-1]}}, x1};
        dy_s = {y2[COORD_W], y2} - {{2{y1[COORD_W-1]}}, y1};
        uni  = r_usum - {1'b0, r_inter};
        over = ({1'b0, r_inter3, 16'h0000} > r_prod);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kept_cnt  <= '0;
            r_issue     <= '0;
            r_supp      <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            if (o_q_pop) begin
                r_issue <= '0;
            end else if (issue) begin
                r_issue <= r_issue + 1'b1;
            end
            if (o_q_pop) begin
                r_supp <= 1'b0;
            end else if (r_v4 && over) begin
                r_supp <= 1'b1;
            end
            if (fire) begin
                if (r_cur.last) begin
                    r_kept_cnt <= '0;
                end else if (keep_now && room) begin
                    r_kept_cnt <= r_kept_cnt + 1'b1;
                end
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_item;
        end
        if (issue) begin
            r_rd <= r_mem[r_issue[ADDR_W-1:0]];
        end
        if (fire && keep_now && room) begin
            r_mem[r_kept_cnt[ADDR_W-1:0]] <= r_cur.geom;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx     <= (dx_s > 0) ? dx_s[SIZE_W-1:0] : '0;
        r_dy     <= (dy_s > 0) ? dy_s[SIZE_W-1:0] : '0;
        r_karea  <= r_rd.area;
        r_inter  <= AREA_W'(r_dx) * AREA_W'(r_dy);
        r_usum   <= {1'b0, r_cur.geom.area} + {1'b0, r_karea};
        r_inter3 <= r_inter;
        r_prod   <= PROD_W'(i_thr) * PROD_W'(uni);
        if (fire) begin
            r_keep  <= keep_now;
            r_full  <= keep_now && !room;
            r_index <= r_cur.index;
            r_done  <= r_cur.last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.keep       = r_keep;
    assign o_res.table_full = r_full;
    assign o_res.box_index  = r_index;
    assign o_res.set_done   = r_done;

endmodule

// ----- rtl/greedy_box_suppression.sv -----
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy IoU suppression of boxes arriving in descending score order.
//
// i_box carries one box per transaction (corner, size, last_box); o_res
// returns one verdict per box in order (keep, box_index, table_full,
// set_done). i_cfg writes the 16 bit overlap threshold; write it only
// while the block is idle. Boxes enter a two-entry queue at the front,
// so up to two boxes are taken while the back end is busy.
// In the back end, one kept entry is read from the table memory and fed
// into the four stage overlap pipeline per cycle, until the box has been
// compared against every kept entry (at most MAX_KEPT).
// When o_res stalls, the result holds in its output register; the back
// end then waits with the next verdict and the queue fills.
// Reset clears the threshold to its default, the kept count and the box
// index; the table contents need no clearing. Both counters also clear
// after the box marked last_box.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module greedy_box_suppression #(
    parameter int unsigned MAX_KEPT = gbs_pkg::MAX_KEPT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gbs_box_if.sink   i_box,
    gbs_res_if.source o_res,
    gbs_cfg_if.sink   i_cfg
);
    import gbs_pkg::*;

    logic [THR_W-1:0] r_thr;
    logic             q_push, q_full, q_pop, q_empty;
    t_box_item        q_in, q_out;
    t_back_stat       s_stat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= IOU_THR_RESET;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.iou_threshold;
        end
    end

    gbs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_box    (i_box),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_item (q_in)
    );

    gbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty)
    );

    gbs_back #(
        .MAX_KEPT (MAX_KEPT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_thr     (r_thr),
        .i_q_empty (q_empty),
        .i_q_item  (q_out),
        .o_q_pop   (q_pop),
        .o_res     (o_res),
        .o_stat    (s_stat)
    );

    `GBS_ASSERT(a_done_pipe_empty, i_clk, i_rst_n, s_stat.in_done |-> !s_stat.pipe_busy)
    `GBS_ASSERT(a_result_from_done, i_clk, i_rst_n, $rose(o_res.valid) |-> $past(s_stat.in_done))
    `GBS_ASSERT_NR(a_full_is_kept, i_clk, o_res.valid && o_res.table_full |-> o_res.keep)

endmodule
